/* rtl/kect_pkg.sv */
// Shared types and constants of the keyed event counter table.
// No dependencies; used by the channel interfaces and the core.
package kect_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int GROUP_SIZE    = 5;
	localparam int CNT_BITS      = 32;
	localparam int KEY_BITS      = 64;

	localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int LANE_W = $clog2(GROUP_SIZE);
	localparam int ROWS   = 2 * TABLE_ENTRIES;
	localparam int ROW_AW = SLOT_W + 1;
	localparam int ROW_W  = GROUP_SIZE * CNT_BITS;

	typedef logic [1:0]          op_t;
	typedef logic [2:0]          status_t;
	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_BITS-1:0] count_t;

	localparam op_t OP_REGISTER = 2'd0;
	localparam op_t OP_COUNT    = 2'd1;
	localparam op_t OP_REPORT   = 2'd2;
	// spare code: accepted, ignored
	localparam op_t OP_UNUSED   = 2'd3;

	localparam status_t ST_COUNTED = 3'd0;
	localparam status_t ST_UNKNOWN = 3'd1;
	localparam status_t ST_PRESENT = 3'd2;
	localparam status_t ST_ADDED   = 3'd3;
	localparam status_t ST_FULL    = 3'd4;
	localparam status_t ST_REPORT  = 3'd5;

endpackage

/* rtl/kect_cmd_if.sv */
// Command channel of the counter table: valid/ready plus one command beat.
// Depends on kect_pkg.
interface kect_cmd_if;
	logic             valid;
	logic             ready;
	kect_pkg::op_t    op;
	kect_pkg::key_t   key;
	logic [3:0]       counter_sel;
	logic             group;

	modport source (output valid, op, key, counter_sel, group, input ready);
	modport sink   (input valid, op, key, counter_sel, group, output ready);
endinterface

/* rtl/kect_rsp_if.sv */
// Result channel of the counter table: valid/ready plus one result beat.
// Depends on kect_pkg.
interface kect_rsp_if;
	logic              valid;
	logic              ready;
	kect_pkg::status_t status;
	logic [2:0]        entry_index;
	kect_pkg::key_t    entry_key;
	kect_pkg::count_t  count_a;
	kect_pkg::count_t  count_b;
	kect_pkg::count_t  count_c;
	kect_pkg::count_t  count_d;
	kect_pkg::count_t  count_e;
	logic              last;

	modport source (output valid, status, entry_index, entry_key, count_a, count_b,
		count_c, count_d, count_e, last, input ready);
	modport sink   (input valid, status, entry_index, entry_key, count_a, count_b,
		count_c, count_d, count_e, last, output ready);
endinterface

/* rtl/keyed_event_counter_table_core.sv */
// Keyed event counter table: key registers, counter row memory, control FSM.
// Depends on kect_pkg, kect_cmd_if and kect_rsp_if.
//
//  channel | role | beat contents
//  --------+------+----------------------------------------------------------
//  cmd     | sink | op, key, counter_sel, group
//  rsp     | src  | status, entry_index, entry_key, count_a..count_e, last
//
// Register and count: accept (parallel key compare, counter row read for count)
// then execute (key store, or increment and write back through the one-port memory).
// Report is accepted, then gives one result per stored entry, one row read each.
// A held result stalls execute/report; a new command is taken while the last
// result still waits. Report clear and slot reuse work on per-row valid flops,
// so there is no clearing sweep after reset.
module keyed_event_counter_table_core (
	input  logic          clk,
	input  logic          arst_n,
	kect_cmd_if.sink      cmd,
	kect_rsp_if.source    rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RPT  = 2'd2;

	logic [1:0] state_q;

	// key registers and fill count
	kect_pkg::key_t                key_q [kect_pkg::TABLE_ENTRIES];
	logic [kect_pkg::CNT_W-1:0]    entry_cnt_q;

	// counter rows: {slot, group} -> five counters
	logic [kect_pkg::ROW_W-1:0]    cnt_mem [kect_pkg::ROWS];
	logic [kect_pkg::ROW_W-1:0]    mem_rdata_q;
	logic                          mem_re, mem_we;
	logic [kect_pkg::ROW_AW-1:0]   mem_raddr;
	logic [kect_pkg::ROW_W-1:0]    mem_wdata;
	logic [kect_pkg::ROWS-1:0]     row_valid_q;

	// command held for execute
	kect_pkg::op_t                 op_s1;
	kect_pkg::key_t                key_s1;
	logic                          hit_s1;
	logic [kect_pkg::SLOT_W-1:0]   slot_s1;
	logic [kect_pkg::ROW_AW-1:0]   row_s1;
	logic [kect_pkg::LANE_W-1:0]   lane_s1;
	logic                          sel_ok_s1;

	logic                          grp_q;
	logic [kect_pkg::SLOT_W-1:0]   rpt_idx_q;

	// output register
	logic                          rsp_valid_q;
	kect_pkg::status_t             rsp_status_q;
	logic [2:0]                    rsp_index_q;
	kect_pkg::key_t                rsp_key_q;
	kect_pkg::count_t              rsp_cnt_q [kect_pkg::GROUP_SIZE];
	logic                          rsp_last_q;

	logic                          cmd_acc, out_free, out_load;
	logic                          lk_hit;
	logic [kect_pkg::SLOT_W-1:0]   lk_slot;
	logic                          sel_hi, sel_ok;
	logic [kect_pkg::LANE_W-1:0]   sel_lane;
	logic [kect_pkg::ROW_W-1:0]    cur_row;
	kect_pkg::count_t              new_cnt;
	logic                          table_full;
	logic                          rpt_last;

	kect_pkg::status_t             o_status;
	logic [2:0]                    o_index;
	kect_pkg::key_t                o_key;
	logic [kect_pkg::ROW_W-1:0]    o_counts;
	logic                          o_last;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// parallel compare over filled slots, lowest slot wins
	always_comb begin
		lk_hit  = 1'b0;
		lk_slot = '0;
		for (int i = kect_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (kect_pkg::CNT_W'(i) < entry_cnt_q && key_q[i] == cmd.key) begin
				lk_hit  = 1'b1;
				lk_slot = kect_pkg::SLOT_W'(i);
			end
		end
	end

	assign sel_hi   = cmd.counter_sel >= 4'(kect_pkg::GROUP_SIZE);
	assign sel_ok   = cmd.counter_sel < 4'(2 * kect_pkg::GROUP_SIZE);
	assign sel_lane = sel_hi ? kect_pkg::LANE_W'(cmd.counter_sel - 4'(kect_pkg::GROUP_SIZE))
	                         : kect_pkg::LANE_W'(cmd.counter_sel);

	assign table_full = entry_cnt_q >= kect_pkg::CNT_W'(kect_pkg::TABLE_ENTRIES);
	assign rpt_last   = (kect_pkg::CNT_W'(rpt_idx_q) + kect_pkg::CNT_W'(1)) == entry_cnt_q;

	// stale rows read as zero
	assign cur_row = row_valid_q[(state_q == S_RPT) ? {rpt_idx_q, grp_q} : row_s1]
	                 ? mem_rdata_q : '0;
	assign new_cnt = cur_row[lane_s1*kect_pkg::CNT_BITS +: kect_pkg::CNT_BITS] + 1'b1;

	// memory read issue
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (cmd_acc && cmd.op == kect_pkg::OP_COUNT && lk_hit && sel_ok) begin
			mem_re    = 1'b1;
			mem_raddr = {lk_slot, sel_hi};
		end else if (cmd_acc && cmd.op == kect_pkg::OP_REPORT && entry_cnt_q != '0) begin
			mem_re    = 1'b1;
			mem_raddr = {kect_pkg::SLOT_W'(0), cmd.group};
		end else if (state_q == S_RPT && out_free && !rpt_last) begin
			mem_re    = 1'b1;
			mem_raddr = {rpt_idx_q + 1'b1, grp_q};
		end
	end

	assign out_load = out_free && (state_q == S_EXEC || state_q == S_RPT);
	assign mem_we   = out_load && state_q == S_EXEC && op_s1 == kect_pkg::OP_COUNT
	                  && hit_s1 && sel_ok_s1;

	always_comb begin
		mem_wdata = cur_row;
		mem_wdata[lane_s1*kect_pkg::CNT_BITS +: kect_pkg::CNT_BITS] = new_cnt;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			cnt_mem[row_s1] <= mem_wdata;
		if (mem_re)
			mem_rdata_q <= cnt_mem[mem_raddr];
	end

	// result beat contents
	always_comb begin
		o_status = kect_pkg::ST_REPORT;
		o_index  = 3'(rpt_idx_q);
		o_key    = key_q[rpt_idx_q];
		o_counts = cur_row;
		o_last   = rpt_last;
		if (state_q == S_EXEC) begin
			o_counts = '0;
			o_last   = 1'b1;
			unique case (op_s1)
				kect_pkg::OP_REGISTER: begin
					if (hit_s1) begin
						o_status = kect_pkg::ST_PRESENT;
						o_index  = 3'(slot_s1);
						o_key    = key_s1;
					end else if (!table_full) begin
						o_status = kect_pkg::ST_ADDED;
						o_index  = 3'(entry_cnt_q);
						o_key    = key_s1;
					end else begin
						o_status = kect_pkg::ST_FULL;
						o_index  = '0;
						o_key    = '0;
					end
				end
				default: begin
					if (hit_s1) begin
						o_status = kect_pkg::ST_COUNTED;
						o_index  = 3'(slot_s1);
						o_key    = key_s1;
						if (sel_ok_s1)
							o_counts[kect_pkg::CNT_BITS-1:0] = new_cnt;
					end else begin
						o_status = kect_pkg::ST_UNKNOWN;
						o_index  = '0;
						o_key    = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			entry_cnt_q <= '0;
			row_valid_q <= '0;
			rpt_idx_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;

			if (mem_we)
				row_valid_q[row_s1] <= 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						if (cmd.op == kect_pkg::OP_REGISTER || cmd.op == kect_pkg::OP_COUNT)
							state_q <= S_EXEC;
						else if (cmd.op == kect_pkg::OP_REPORT) begin
							rpt_idx_q <= '0;
							if (entry_cnt_q != '0)
								state_q <= S_RPT;
							else
								row_valid_q <= '0;
						end
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (op_s1 == kect_pkg::OP_REGISTER && !hit_s1 && !table_full) begin
							entry_cnt_q <= entry_cnt_q + 1'b1;
							row_valid_q[{entry_cnt_q[kect_pkg::SLOT_W-1:0], 1'b0}] <= 1'b0;
							row_valid_q[{entry_cnt_q[kect_pkg::SLOT_W-1:0], 1'b1}] <= 1'b0;
						end
					end
				end
				S_RPT: begin
					if (out_free) begin
						if (rpt_last) begin
							state_q     <= S_IDLE;
							row_valid_q <= '0;
						end else begin
							rpt_idx_q <= rpt_idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_s1     <= cmd.op;
			key_s1    <= cmd.key;
			hit_s1    <= lk_hit;
			slot_s1   <= lk_slot;
			row_s1    <= {lk_slot, sel_hi};
			lane_s1   <= sel_lane;
			sel_ok_s1 <= sel_ok;
			grp_q     <= cmd.group;
		end
		if (out_load && state_q == S_EXEC && op_s1 == kect_pkg::OP_REGISTER
		    && !hit_s1 && !table_full)
			key_q[entry_cnt_q[kect_pkg::SLOT_W-1:0]] <= key_s1;
		if (out_load) begin
			rsp_status_q <= o_status;
			rsp_index_q  <= o_index;
			rsp_key_q    <= o_key;
			rsp_last_q   <= o_last;
			for (int j = 0; j < kect_pkg::GROUP_SIZE; j++)
				rsp_cnt_q[j] <= o_counts[j*kect_pkg::CNT_BITS +: kect_pkg::CNT_BITS];
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_index = rsp_index_q;
	assign rsp.entry_key   = rsp_key_q;
	assign rsp.count_a     = rsp_cnt_q[0];
	assign rsp.count_b     = rsp_cnt_q[1];
	assign rsp.count_c     = rsp_cnt_q[2];
	assign rsp.count_d     = rsp_cnt_q[3];
	assign rsp.count_e     = rsp_cnt_q[4];
	assign rsp.last        = rsp_last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= kect_pkg::CNT_W'(kect_pkg::TABLE_ENTRIES))
		else $error("fill count beyond table size");

	a_rpt_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RPT |-> kect_pkg::CNT_W'(rpt_idx_q) < entry_cnt_q)
		else $error("report index past filled slots");

	a_rpt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RPT && out_free && rpt_last) |=> row_valid_q == '0)
		else $error("counters not cleared after report");

	a_row_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid_q >> {entry_cnt_q, 1'b0}) == '0)
		else $error("live counter row for an empty slot");

endmodule
